// ----- hdl/dle_etx_frame_deframer_top_defines.svh -----
// Assertion macros used by the DLE/ETX deframer top level.
`ifndef DLE_ETX_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define DLE_ETX_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DLE_ETX_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define DLE_ETX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/dle_etx_pkg.sv -----
// Types and constants shared by the DLE/ETX deframer modules.
`default_nettype none

package dle_etx_pkg;

    // Frame buffer size in bytes; a frame that reaches it is aborted.
    localparam int unsigned BUFFER_BYTES = 128;

    // Framing codes.
    localparam logic [7:0] DLE_CODE = 8'h10;
    localparam logic [7:0] ETX_CODE = 8'h03;

    // Event kinds reported on the result channel.
    localparam logic [1:0] EV_PAYLOAD  = 2'd0;
    localparam logic [1:0] EV_DONE     = 2'd1;
    localparam logic [1:0] EV_EMPTY    = 2'd2;
    localparam logic [1:0] EV_OVERFLOW = 2'd3;

    // One result request.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload;
        logic [7:0] length;
    } dle_etx_res_t;

    // Frame state visible to the top level for checking.
    typedef struct packed {
        logic       hunting;
        logic [7:0] kept_count;
        logic       held_valid;
    } dle_etx_core_stat_t;

    // Occupancy of the output buffer.
    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } dle_etx_obuf_stat_t;

endpackage

`default_nettype wire

// ----- hdl/dle_etx_core.sv -----
// Frame state and single-pass unstuffing logic of the DLE/ETX deframer.
`default_nettype none

module dle_etx_core
    import dle_etx_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_fire,
    input  wire logic [7:0]         rx_byte,
    output logic                    res_valid,
    output dle_etx_res_t            res,
    output dle_etx_core_stat_t      stat
);

    logic       hunting_reg, hunting_next;
    logic [7:0] kept_count_reg, kept_count_next;
    logic       dle_parity_reg, dle_parity_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;

    // Next frame state and the result caused by the accepted byte.
    always_comb
    begin
        logic       keep;
        logic [8:0] count_inc;

        keep            = 1'b0;
        count_inc       = {1'b0, kept_count_reg} + 9'd1;
        hunting_next    = hunting_reg;
        kept_count_next = kept_count_reg;
        dle_parity_next = dle_parity_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        res_valid       = 1'b0;
        res             = '0;

        if (in_fire)
        begin
            if (hunting_reg)
            begin
                // A start byte opens a fresh frame; anything else is discarded.
                if (rx_byte == DLE_CODE)
                begin
                    hunting_next    = 1'b0;
                    kept_count_next = '0;
                    dle_parity_next = 1'b0;
                    held_byte_next  = '0;
                    held_valid_next = 1'b0;
                end
            end
            else
            begin
                if (rx_byte == DLE_CODE)
                begin
                    // The second byte of a stuffed pair is dropped.
                    dle_parity_next = ~dle_parity_reg;
                    keep            = ~dle_parity_reg;
                end
                else if (rx_byte == ETX_CODE && dle_parity_reg)
                begin
                    // End of frame: the held trailer byte is discarded.
                    hunting_next    = 1'b1;
                    kept_count_next = '0;
                    dle_parity_next = 1'b0;
                    held_byte_next  = '0;
                    held_valid_next = 1'b0;
                    res_valid       = 1'b1;
                    if (kept_count_reg <= 8'd1)
                    begin
                        res.kind = EV_EMPTY;
                    end
                    else
                    begin
                        res.kind   = EV_DONE;
                        res.length = kept_count_reg - 8'd1;
                    end
                end
                else
                begin
                    keep = 1'b1;
                end

                if (keep)
                begin
                    if (count_inc >= 9'(BUFFER_BYTES))
                    begin
                        // Buffer full: abort the frame and hunt again.
                        hunting_next    = 1'b1;
                        kept_count_next = '0;
                        dle_parity_next = 1'b0;
                        held_byte_next  = '0;
                        held_valid_next = 1'b0;
                        res_valid       = 1'b1;
                        res.kind        = EV_OVERFLOW;
                    end
                    else
                    begin
                        // Hold this byte and release the previous one.
                        kept_count_next = count_inc[7:0];
                        held_byte_next  = rx_byte;
                        held_valid_next = 1'b1;
                        if (held_valid_reg)
                        begin
                            res_valid   = 1'b1;
                            res.kind    = EV_PAYLOAD;
                            res.payload = held_byte_reg;
                        end
                    end
                end
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg    <= 1'b1;
            kept_count_reg <= '0;
            dle_parity_reg <= 1'b0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            hunting_reg    <= hunting_next;
            kept_count_reg <= kept_count_next;
            dle_parity_reg <= dle_parity_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
        end
    end

    assign stat.hunting    = hunting_reg;
    assign stat.kept_count = kept_count_reg;
    assign stat.held_valid = held_valid_reg;

endmodule

`default_nettype wire

// ----- hdl/dle_etx_obuf.sv -----
// Output register with a skid stage for the deframer result channel.
`default_nettype none

module dle_etx_obuf
    import dle_etx_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire dle_etx_res_t       push_res,
    output logic                    full,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output dle_etx_res_t            out_res,
    output dle_etx_obuf_stat_t      stat
);

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    dle_etx_res_t main_res_reg, main_res_next;
    dle_etx_res_t skid_res_reg, skid_res_next;
    logic         pop;

    assign pop = main_valid_reg & ~out_stall;

    // Move requests between the skid stage and the output register.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_res_next   = main_res_reg;
        skid_res_next   = skid_res_reg;

        if (skid_valid_reg)
        begin
            // No push is taken while the skid stage is occupied.
            if (pop)
            begin
                main_res_next   = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_res_next   = push_res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_res_next   = push_res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    // Control state is reset; the request payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_res_reg <= main_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign full            = skid_valid_reg;
    assign out_valid       = main_valid_reg;
    assign out_res         = main_res_reg;
    assign stat.main_valid = main_valid_reg;
    assign stat.skid_valid = skid_valid_reg;

endmodule

`default_nettype wire

// ----- hdl/dle_etx_frame_deframer_top.sv -----
// DLE/ETX byte-unstuffing deframer, top level.
// A result request caused by a byte reaches out_valid through the output register or its skid stage.
// One received byte per cycle while in_stall is low (single-pass frame state update).
// in_stall rises only when the output register and its skid stage both hold requests.
// Reset (rst_n, asynchronous, active low) empties both stages and starts hunting.
`default_nettype none

`include "dle_etx_frame_deframer_top_defines.svh"

module dle_etx_frame_deframer_top
    import dle_etx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      event_kind,
    output logic [7:0]      payload_byte,
    output logic [7:0]      frame_length
);

    logic               in_fire;
    logic               res_valid;
    dle_etx_res_t       res;
    dle_etx_res_t       out_res;
    logic               buf_full;
    dle_etx_core_stat_t core_stat;
    dle_etx_obuf_stat_t obuf_stat;

    // A byte is taken whenever the skid stage is free.
    assign in_stall = buf_full;
    assign in_fire  = in_valid & ~buf_full;

    dle_etx_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res),
        .stat      (core_stat)
    );

    dle_etx_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res),
        .stat      (obuf_stat)
    );

    assign event_kind   = out_res.kind;
    assign payload_byte = out_res.payload;
    assign frame_length = out_res.length;

    // Checks on frame state and buffer occupancy.
    `DLE_ETX_ASSERT_IMPL(a_skid_behind_main, obuf_stat.skid_valid, obuf_stat.main_valid, "skid holds a request while the output register is empty")
    `DLE_ETX_ASSERT_IMPL(a_hunt_clear, core_stat.hunting, (core_stat.kept_count == 8'd0) && !core_stat.held_valid, "frame state not cleared while hunting")
    `DLE_ETX_ASSERT_IMPL(a_count_bound, 1'b1, core_stat.kept_count < 8'(BUFFER_BYTES), "kept count reached the buffer size")
    `DLE_ETX_ASSERT_NEXT(a_push_lands, res_valid && !obuf_stat.skid_valid, out_valid, "pushed request did not reach the output")

endmodule

`default_nettype wire

// ----- tb/sv/dle_etx_frame_deframer_checker.sv -----
// Checker for the DLE/ETX deframer: predicts the event stream and compares it with the block.
module dle_etx_frame_deframer_checker
    import dle_etx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [1:0] event_kind,
    input  wire logic [7:0] payload_byte,
    input  wire logic [7:0] frame_length,
    output int              mismatch_count,
    output int              awaited_count
);

    // Our own copy of the frame state.
    logic       hunting;
    logic [7:0] kept_count;
    logic       dle_parity;
    logic [7:0] held_byte;
    logic       held_valid;

    // Events still to come from the block, oldest first.
    dle_etx_res_t pending_events[$];
    dle_etx_res_t oldest_event;

    // Forget everything about the current frame.
    task automatic drop_frame();
        kept_count = '0;
        dle_parity = 1'b0;
        held_byte  = '0;
        held_valid = 1'b0;
    endtask

    // Advance the frame state by one received byte and queue any event it causes.
    task automatic deframe_byte(input logic [7:0] c);
        dle_etx_res_t ev;
        logic [7:0]   frame_bytes;
        ev = '0;
        if (hunting) begin
            if (c == DLE_CODE) begin
                hunting = 1'b0;
                drop_frame();
            end
            return;
        end
        // The second byte of a stuffed pair is thrown away.
        if (c == DLE_CODE && dle_parity) begin
            dle_parity = 1'b0;
            return;
        end
        // End of frame: the held trailer byte is not part of the payload.
        if (c == ETX_CODE && dle_parity) begin
            frame_bytes = kept_count;
            hunting     = 1'b1;
            drop_frame();
            if (frame_bytes <= 8'd1) begin
                ev.kind = EV_EMPTY;
            end
            else begin
                ev.kind   = EV_DONE;
                ev.length = frame_bytes - 8'd1;
            end
            pending_events.push_back(ev);
            return;
        end
        if (c == DLE_CODE) begin
            dle_parity = 1'b1;
        end
        // Keep the byte; a full buffer aborts the frame.
        kept_count = kept_count + 8'd1;
        if (kept_count >= BUFFER_BYTES) begin
            hunting = 1'b1;
            drop_frame();
            ev.kind = EV_OVERFLOW;
            pending_events.push_back(ev);
            return;
        end
        if (held_valid) begin
            ev.kind    = EV_PAYLOAD;
            ev.payload = held_byte;
            pending_events.push_back(ev);
        end
        held_byte  = c;
        held_valid = 1'b1;
    endtask

    // Count a mismatch and report the first few in full.
    task automatic log_mismatch(input string why, input dle_etx_res_t want);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected kind %0d payload %02h length %0d, got kind %0d payload %02h length %0d",
                     $realtime, why, want.kind, want.payload, want.length,
                     event_kind, payload_byte, frame_length);
        end
    endtask

    // Results are compared before the request taken at the same edge is predicted,
    // since a result always belongs to an earlier request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hunting = 1'b1;
            drop_frame();
            pending_events.delete();
            mismatch_count = 0;
            awaited_count  = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (pending_events.size() == 0) begin
                    log_mismatch("unexpected result", '0);
                end
                else begin
                    oldest_event = pending_events.pop_front();
                    if (event_kind !== oldest_event.kind
                        || payload_byte !== oldest_event.payload
                        || frame_length !== oldest_event.length) begin
                        log_mismatch("wrong result", oldest_event);
                    end
                end
            end
            if (in_valid && !in_stall) begin
                deframe_byte(rx_byte);
            end
            awaited_count = pending_events.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the DLE/ETX deframer testbench: clock, reset, byte stimulus and the verdict.
module tb
    import dle_etx_pkg::*;
();

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_stall = 1'b0;
    logic       calm      = 1'b0;
    wire logic       in_stall;
    wire logic       out_valid;
    wire logic [1:0] event_kind;
    wire logic [7:0] payload_byte;
    wire logic [7:0] frame_length;
    int         mismatch_count;
    int         awaited_count;
    int         bytes_sent = 0;
    int         frame_no;
    int         mix;
    logic [7:0] opening_bytes [0:21];

    dle_etx_frame_deframer_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .payload_byte (payload_byte),
        .frame_length (frame_length)
    );

    dle_etx_frame_deframer_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .payload_byte   (payload_byte),
        .frame_length   (frame_length),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    always #2 clk = ~clk;

    // The receiver stalls at random, except during the calm stretch.
    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 16);
    end

    // Offer one byte, with random idle cycles first, and hold it until it is taken.
    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 16) begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom_range(255));
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        calm     <= (bytes_sent >= 500 && bytes_sent < 700);
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Byte values weighted towards the framing codes.
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) begin
            return DLE_CODE;
        end
        if (r < 30) begin
            return ETX_CODE;
        end
        return 8'($urandom_range(255));
    endfunction

    // A well-formed frame: start byte, stuffed payload, trailer.
    task automatic send_frame(input int unsigned payload_len);
        logic [7:0] b;
        send_byte(DLE_CODE);
        for (int unsigned i = 0; i < payload_len; i++) begin
            b = pick_byte();
            send_byte(b);
            if (b == DLE_CODE) begin
                send_byte(DLE_CODE);
            end
        end
        send_byte(DLE_CODE);
        send_byte(ETX_CODE);
    endtask

    // Unstructured bytes, heavy in framing codes.
    task automatic send_ragged(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            send_byte(pick_byte());
        end
    endtask

    // Give up if the run hangs.
    initial
    begin
        #2000000;
        $display("** dle_etx_frame_deframer_top: FAILED **");
        $finish;
    end

    initial
    begin
        // Noise while hunting, an empty frame, a frame with every special case
        // (ETX at even parity, stuffed pair, stray byte after a lone DLE),
        // and a one-byte frame.
        opening_bytes = '{8'h00, 8'hFF, 8'h03,
                          8'h10, 8'h10, 8'h03,
                          8'h10, 8'h03, 8'h10, 8'h10, 8'h55, 8'h10,
                          8'hAA, 8'hFF, 8'h00, 8'h10, 8'h10, 8'h03,
                          8'h10, 8'h7E, 8'h10, 8'h03};
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening_bytes[i]) begin
            send_byte(opening_bytes[i]);
        end

        // Mostly clean frames of short length, a few near the buffer size,
        // and some broken or ragged sequences.
        frame_no = 0;
        while (bytes_sent < 1050) begin
            mix = $urandom_range(99);
            if (frame_no == 0) begin
                send_frame(BUFFER_BYTES - 2);
            end
            else if (frame_no == 1) begin
                send_frame(BUFFER_BYTES - 1);
            end
            else if (mix < 3) begin
                send_frame($urandom_range(BUFFER_BYTES + 4, BUFFER_BYTES - 6));
            end
            else if (mix < 80) begin
                send_frame($urandom_range(12, 0));
            end
            else if (mix < 92) begin
                send_byte(DLE_CODE);
                send_ragged($urandom_range(10, 1));
            end
            else begin
                send_ragged($urandom_range(6, 1));
            end
            frame_no++;
        end
        in_valid <= 1'b0;

        // Drain, then allow time for anything stray to appear.
        while (awaited_count != 0) begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);

        if (mismatch_count == 0) begin
            $display("** dle_etx_frame_deframer_top: PASSED **");
        end
        else begin
            $display("** dle_etx_frame_deframer_top: FAILED **");
        end
        $finish;
    end

endmodule
